### rtl/core/yrtp_pkg.sv
// shared constants and types for the radial yuv test pattern block
package yrtp_pkg;

	// default frame size
	localparam int FRAME_WIDTH_DEF  = 320;
	localparam int FRAME_HEIGHT_DEF = 240;

	// port field widths
	localparam int ROW_W  = 8;
	localparam int COL_W  = 9;
	localparam int BYTE_W = 8;

	// q.16 fixed point
	localparam int FRAC_W   = 16;
	localparam int ONE_Q16  = 65536;
	localparam int HALF_Q16 = 32768;

	// conversion coefficients, rounded to q.16
	localparam logic signed [18:0] K_R_V = 19'sd74711;
	localparam logic signed [18:0] K_G_U = 19'sd26214;
	localparam logic signed [18:0] K_G_V = 19'sd38011;
	localparam logic signed [18:0] K_B_U = 19'sd133038;
	localparam int K_W = 19;

	// reciprocal divide by frame size: exact for 25 bit dividends and sizes up to 4096
	localparam int RECIP_SHIFT = 37;
	localparam int RECIP_W     = 37;

	// internal widths
	localparam int DELTA_W  = 13;	// signed offset from frame center
	localparam int UQ_W     = 23;	// row / height in q.16
	localparam int VQ_W     = 24;	// col / width in q.16
	localparam int CHROMA_W = 25;	// signed u and v
	localparam int TERM_W   = 28;	// signed coefficient products
	localparam int CLIP_W   = 17;	// clipped channel, 0 to one

	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [COL_W-1:0]  col_t;
	typedef logic [BYTE_W-1:0] byte_t;

endpackage

### rtl/core/yrtp_pix_if.sv
// pixel coordinate channel: valid, ready, row and column
interface yrtp_pix_if import yrtp_pkg::*; ();
	logic valid;
	logic ready;
	row_t row;
	col_t col;

	modport source (output valid, output row, output col, input ready);
	modport sink (input valid, input row, input col, output ready);
endinterface

### rtl/core/yrtp_rgb_if.sv
// rgb pixel channel: valid, ready and the three channel bytes
interface yrtp_rgb_if import yrtp_pkg::*; ();
	logic valid;
	logic ready;
	byte_t red;
	byte_t green;
	byte_t blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

### rtl/core/yuv_radial_test_pattern.sv
// radial yuv test pattern generator, deep pipeline from pixel coordinate to rgb word
//
//  channel  dir  word                      handshake
//  pix      in   row[7:0], col[8:0]        valid/ready
//  rgb      out  red, green, blue [7:0]    valid/ready
//
// one word per clock sustained while rgb is ready; the pipeline depth is set by the
// square-root chain, which resolves one result bit per stage
// arst_n clears only the valid bits of the stages; data registers are not reset
// a stage holds while its successor is full and stalled; empty stages close up, so
// new words are taken while a finished word waits on rgb
module yuv_radial_test_pattern import yrtp_pkg::*; #(
	parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
	input logic clk,
	input logic arst_n,
	yrtp_pix_if.sink pix,
	yrtp_rgb_if.source rgb
);

	// frame geometry
	localparam int CX = (FRAME_WIDTH - 1) / 2;
	localparam int CY = (FRAME_HEIGHT - 1) / 2;
	localparam int DX_FAR = (2**COL_W - 1 - CX > CX) ? (2**COL_W - 1 - CX) : CX;
	localparam int DY_FAR = (2**ROW_W - 1 - CY > CY) ? (2**ROW_W - 1 - CY) : CY;
	localparam int S_MAX = DX_FAR * DX_FAR + DY_FAR * DY_FAR;
	localparam int S_W = $clog2(S_MAX + 1);

	// squared corner distance, never zero
	localparam int D_RAW = CX * CX + CY * CY;
	localparam int D_EFF = (D_RAW == 0) ? 1 : D_RAW;
	localparam int D_W = $clog2(D_EFF + 1);

	// root search widths
	localparam int T_W = S_W + 2 * FRAC_W;		// scaled squared distance
	localparam int R_W = (T_W + 1) / 2;		// distance ratio bits
	localparam int RD_W = R_W + D_W;		// ratio times corner distance
	localparam int X_W = 2 * R_W + D_W + 2;		// trial decrement

	// output side widths
	localparam int L_W = R_W + 2;
	localparam int SUM_W = ((L_W > TERM_W) ? L_W : TERM_W) + 2;

	// stage indexes: s1, s2, root chain seed and R_W root steps, clip, output
	localparam int ST_SEED = 2;
	localparam int ST_ROOT = ST_SEED + R_W;
	localparam int ST_CLIP = ST_ROOT + 1;
	localparam int ST_OUT = ST_CLIP + 1;
	localparam int NS = ST_OUT + 1;

	// reciprocals for the u and v divides
	localparam longint unsigned RECIP_H_FULL =
		((64'd1 << RECIP_SHIFT) + 64'(FRAME_HEIGHT) - 64'd1) / 64'(FRAME_HEIGHT);
	localparam longint unsigned RECIP_W_FULL =
		((64'd1 << RECIP_SHIFT) + 64'(FRAME_WIDTH) - 64'd1) / 64'(FRAME_WIDTH);
	localparam logic [RECIP_W-1:0] RECIP_H = RECIP_W'(RECIP_H_FULL);
	localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP_W_FULL);

	localparam logic signed [DELTA_W-1:0] CX_S = DELTA_W'(CX);
	localparam logic signed [DELTA_W-1:0] CY_S = DELTA_W'(CY);
	localparam logic signed [CHROMA_W-1:0] HALF_S = CHROMA_W'(HALF_Q16);
	localparam logic signed [SUM_W-1:0] ONE_S = SUM_W'(ONE_Q16);

	localparam int PROD_W = K_W + CHROMA_W;

	typedef struct packed {
		logic [T_W-1:0]           resid;	// remaining t - root^2 * d
		logic [RD_W-1:0]          rd;		// root * d
		logic [R_W-1:0]           root;
		logic signed [TERM_W-1:0] tr;
		logic signed [TERM_W-1:0] tg;
		logic signed [TERM_W-1:0] tb;
	} root_t;

	function automatic logic [CLIP_W-1:0] clip_q16(input logic signed [SUM_W-1:0] x);
		logic [CLIP_W-1:0] y;
		if (x < 0) begin
			y = '0;
		end else if (x > ONE_S) begin
			y = CLIP_W'(ONE_Q16);
		end else begin
			y = x[CLIP_W-1:0];
		end
		return y;
	endfunction

	// ---------------------------------------------------------------
	// flow control
	// ---------------------------------------------------------------
	logic [NS-1:0] vld_q;
	logic [NS-1:0] en;
	logic [NS-1:0] vld_prev;

	// a stage loads when it or any stage after it is empty, or the sink takes the word
	always_comb begin
		logic [NS-1:0] low;
		for (int k = 0; k < NS; k++) begin
			low = (NS'(1) << k) - NS'(1);
			en[k] = rgb.ready || !(&(vld_q | low));
		end
	end

	assign vld_prev = {vld_q[NS-2:0], pix.valid};
	assign pix.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_prev[k];
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// s1: center offsets, row and column scaled by the frame size
	// ---------------------------------------------------------------
	logic signed [DELTA_W-1:0] dx_s1, dy_s1;
	logic [UQ_W-1:0] uq_s1;
	logic [VQ_W-1:0] vq_s1;
	logic [ROW_W+RECIP_W-1:0] u_prod;
	logic [COL_W+RECIP_W-1:0] v_prod;

	assign u_prod = pix.row * RECIP_H;
	assign v_prod = pix.col * RECIP_V;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			dx_s1 <= $signed(DELTA_W'(pix.col)) - CX_S;
			dy_s1 <= $signed(DELTA_W'(pix.row)) - CY_S;
			uq_s1 <= UQ_W'(u_prod >> (RECIP_SHIFT - FRAC_W));
			vq_s1 <= VQ_W'(v_prod >> (RECIP_SHIFT - FRAC_W));
		end
	end

	// ---------------------------------------------------------------
	// s2: squared distance, centered chroma
	// ---------------------------------------------------------------
	logic [S_W-1:0] dist_s2;
	logic signed [CHROMA_W-1:0] u_s2, v_s2;
	logic signed [2*DELTA_W:0] dist_sq;

	assign dist_sq = dx_s1 * dx_s1 + dy_s1 * dy_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			dist_s2 <= S_W'(dist_sq);
			u_s2 <= $signed(CHROMA_W'(uq_s1)) - HALF_S;
			v_s2 <= $signed(CHROMA_W'(vq_s1)) - HALF_S;
		end
	end

	// ---------------------------------------------------------------
	// stage 3: chroma products, seed of the root chain
	// ---------------------------------------------------------------
	root_t root_s [R_W+1];
	logic signed [PROD_W-1:0] p_rv, p_gu, p_gv, p_bu;

	assign p_rv = K_R_V * v_s2;
	assign p_gu = K_G_U * u_s2;
	assign p_gv = K_G_V * v_s2;
	assign p_bu = K_B_U * u_s2;

	// arithmetic shift floors toward minus infinity
	always_ff @(posedge clk) begin
		if (en[ST_SEED]) begin
			root_s[0].resid <= {dist_s2, {(2*FRAC_W){1'b0}}};
			root_s[0].rd <= '0;
			root_s[0].root <= '0;
			root_s[0].tr <= TERM_W'(p_rv >>> FRAC_W);
			root_s[0].tg <= -TERM_W'(p_gu >>> FRAC_W) - TERM_W'(p_gv >>> FRAC_W);
			root_s[0].tb <= TERM_W'(p_bu >>> FRAC_W);
		end
	end

	// ---------------------------------------------------------------
	// root chain: largest r with r^2 * d <= s * 2^32, one bit per stage
	// setting bit b raises r^2 * d by (r * d) << (b + 1) plus d << 2b
	// ---------------------------------------------------------------
	for (genvar j = 0; j < R_W; j++) begin : g_root
		localparam int BIT = R_W - 1 - j;
		logic [X_W-1:0] dec;
		logic fit;
		root_t nxt;

		assign dec = (X_W'(root_s[j].rd) << (BIT + 1)) + (X_W'(D_EFF) << (2 * BIT));
		assign fit = dec <= X_W'(root_s[j].resid);

		always_comb begin
			nxt = root_s[j];
			if (fit) begin
				nxt.resid = root_s[j].resid - T_W'(dec);
				nxt.rd = root_s[j].rd + (RD_W'(D_EFF) << BIT);
				nxt.root[BIT] = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (en[ST_SEED+1+j]) begin
				root_s[j+1] <= nxt;
			end
		end
	end

	// ---------------------------------------------------------------
	// s4: luminance, channel sums, clip to [0, 1]
	// ---------------------------------------------------------------
	logic [CLIP_W-1:0] red_s4, green_s4, blue_s4;
	logic signed [SUM_W-1:0] luma, sum_r, sum_g, sum_b;

	// luminance goes negative beyond the corner; the clip handles it
	assign luma = ONE_S - $signed(SUM_W'(root_s[R_W].root));
	assign sum_r = luma + SUM_W'(root_s[R_W].tr);
	assign sum_g = luma + SUM_W'(root_s[R_W].tg);
	assign sum_b = luma + SUM_W'(root_s[R_W].tb);

	always_ff @(posedge clk) begin
		if (en[ST_CLIP]) begin
			red_s4 <= clip_q16(sum_r);
			green_s4 <= clip_q16(sum_g);
			blue_s4 <= clip_q16(sum_b);
		end
	end

	// ---------------------------------------------------------------
	// s5: scale by 255 and truncate, output register
	// ---------------------------------------------------------------
	logic [BYTE_W-1:0] red_s5, green_s5, blue_s5;
	logic [CLIP_W+BYTE_W-1:0] sc_r, sc_g, sc_b;

	assign sc_r = {red_s4, {BYTE_W{1'b0}}} - (CLIP_W+BYTE_W)'(red_s4);
	assign sc_g = {green_s4, {BYTE_W{1'b0}}} - (CLIP_W+BYTE_W)'(green_s4);
	assign sc_b = {blue_s4, {BYTE_W{1'b0}}} - (CLIP_W+BYTE_W)'(blue_s4);

	always_ff @(posedge clk) begin
		if (en[ST_OUT]) begin
			red_s5 <= sc_r[FRAC_W+BYTE_W-1:FRAC_W];
			green_s5 <= sc_g[FRAC_W+BYTE_W-1:FRAC_W];
			blue_s5 <= sc_b[FRAC_W+BYTE_W-1:FRAC_W];
		end
	end

	assign rgb.valid = vld_q[ST_OUT];
	assign rgb.red = red_s5;
	assign rgb.green = green_s5;
	assign rgb.blue = blue_s5;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------

	// an empty output register opens the whole pipe
	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[ST_OUT] |-> pix.ready)
		else $error("input stalled with an empty output register");

	// a full stage that cannot advance keeps its word
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q & ~en) != '0 |=> (($past(vld_q & ~en) & ~vld_q) == '0))
		else $error("stalled word dropped from a stage");

	// the finished root is maximal and its running product is consistent
	a_root_max: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[ST_ROOT] |->
			(X_W'(root_s[R_W].resid) < ((X_W'(root_s[R_W].rd) << 1) + X_W'(D_EFF))) &&
			(X_W'(root_s[R_W].root) * X_W'(D_EFF) == X_W'(root_s[R_W].rd)))
		else $error("distance ratio not the floor of the square root");

	// clipped channels never exceed one
	a_clip_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[ST_OUT-1] |-> (red_s4 <= CLIP_W'(ONE_Q16)) && (green_s4 <= CLIP_W'(ONE_Q16)) &&
			(blue_s4 <= CLIP_W'(ONE_Q16)))
		else $error("channel above one after clip");

endmodule
